@@ src/dlpo_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the dust sensor low-pulse occupancy meter.
package dlpo_pkg;

    // Event kinds carried in the command field
    typedef enum logic [1:0] {
        CMD_FALL = 2'd0,
        CMD_RISE = 2'd1,
        CMD_TICK = 2'd2
    } cmd_t;

    // Configuration register indexes
    localparam logic CFG_WINDOW_LAST = 1'b0;
    localparam logic CFG_EDGE_COMP   = 1'b1;

    localparam logic [7:0]  WINDOW_LAST_RST = 8'd7;
    localparam logic [15:0] EDGE_COMP_RST   = 16'd20000;

    // Count conversion: below the knee count = sum*3/1792, above it
    // count = 4500 + (sum - knee)/448. Both divisions by 7 use reciprocals.
    localparam logic [21:0] KNEE_SUM   = 22'd2688000;
    localparam logic [15:0] KNEE_COUNT = 16'd4500;
    localparam logic [15:0] RECIP7_LO  = 16'd37450;   // ceil(2^18/7)
    localparam logic [19:0] RECIP7_HI  = 20'd599187;  // ceil(2^22/7)
    localparam logic [18:0] HI_LIMIT   = 19'd427252;  // 7*61036, saturation point

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] timestamp_us;
    } in_item_t;

    typedef struct packed {
        logic [15:0] particle_count;
        logic        indicator_level;
    } out_item_t;

    // Qualified event strobes for the current item
    typedef struct packed {
        logic fall;
        logic rise;
        logic tick;
    } evt_t;

    // Window state seen by the top level
    typedef struct packed {
        logic at_last;
        logic indicator_next;
    } win_status_t;

endpackage

@@ src/dlpo_pulse_acc.sv @@
`timescale 1ns / 1ps
// Low pulse timing and running sum of low durations.
module dlpo_pulse_acc #(
    parameter int SUM_WIDTH = 40
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dlpo_pkg::evt_t       evt,
    input  logic                 clear_sum,
    input  logic [31:0]          timestamp_us,
    input  logic [15:0]          edge_comp,
    output logic [SUM_WIDTH-1:0] low_sum
);

    logic [31:0]          fall_stamp_reg;
    logic [31:0]          last_dur_reg;
    logic [SUM_WIDTH-1:0] sum_reg;

    logic [31:0]          elapsed;
    logic [32:0]          dur_wide;
    logic [31:0]          dur_sat;
    logic [31:0]          dur_eff;
    logic [SUM_WIDTH:0]   sum_inc;
    logic [SUM_WIDTH-1:0] sum_next;

    assign elapsed  = timestamp_us - fall_stamp_reg;
    assign dur_wide = {17'd0, edge_comp} + {1'b0, elapsed};
    assign dur_sat  = dur_wide[32] ? '1 : dur_wide[31:0];
    // keep the stale duration unless the rise is later than the fall
    assign dur_eff  = (timestamp_us > fall_stamp_reg) ? dur_sat : last_dur_reg;
    assign sum_inc  = {1'b0, sum_reg} + (SUM_WIDTH + 1)'(dur_eff);
    assign sum_next = sum_inc[SUM_WIDTH] ? '1 : sum_inc[SUM_WIDTH-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fall_stamp_reg <= '0;
            last_dur_reg   <= '0;
            sum_reg        <= '0;
        end else begin
            if (evt.fall) begin
                fall_stamp_reg <= timestamp_us;
            end
            if (evt.rise) begin
                last_dur_reg <= dur_eff;
                sum_reg      <= sum_next;
            end else if (clear_sum) begin
                sum_reg <= '0;
            end
        end
    end

    assign low_sum = sum_reg;

endmodule

@@ src/dlpo_count_conv.sv @@
`timescale 1ns / 1ps
// Conversion of the window's low time sum into a saturated particle count.
module dlpo_count_conv #(
    parameter int SUM_WIDTH = 40
) (
    input  logic [SUM_WIDTH-1:0] low_sum,
    output logic [15:0]          particle_count
);

    logic [22:0]          lo_x3;
    logic [14:0]          lo_div;
    logic [30:0]          lo_prod;
    logic [SUM_WIDTH-1:0] hi_above;
    logic [SUM_WIDTH-7:0] hi_div;
    logic                 hi_sat;
    logic [38:0]          hi_prod;
    logic                 below_knee;

    assign below_knee = low_sum <= SUM_WIDTH'(dlpo_pkg::KNEE_SUM);

    // sum*3/256, then divide by 7
    assign lo_x3   = {low_sum[21:0], 1'b0} + {1'b0, low_sum[21:0]};
    assign lo_div  = lo_x3[22:8];
    assign lo_prod = 31'(lo_div) * 31'(dlpo_pkg::RECIP7_LO);

    // (sum-knee)/64, then divide by 7
    assign hi_above = low_sum - SUM_WIDTH'(dlpo_pkg::KNEE_SUM);
    assign hi_div   = hi_above[SUM_WIDTH-1:6];
    assign hi_sat   = hi_div >= (SUM_WIDTH - 6)'(dlpo_pkg::HI_LIMIT);
    assign hi_prod  = 39'(hi_div[18:0]) * 39'(dlpo_pkg::RECIP7_HI);

    always_comb begin
        if (below_knee) begin
            particle_count = 16'(lo_prod[30:18]);
        end else if (hi_sat) begin
            particle_count = '1;
        end else begin
            particle_count = dlpo_pkg::KNEE_COUNT + hi_prod[37:22];
        end
    end

endmodule

@@ src/dlpo_window.sv @@
`timescale 1ns / 1ps
// Overflow tick counter and indicator bit of the measurement window.
module dlpo_window (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  dlpo_pkg::evt_t            evt,
    input  logic [7:0]                window_last,
    output dlpo_pkg::win_status_t     status
);

    logic [7:0] count_reg;
    logic       indicator_reg;
    logic       at_last;

    assign at_last = count_reg == window_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            indicator_reg <= 1'b0;
        end else if (evt.tick) begin
            if (at_last) begin
                count_reg     <= '0;
                indicator_reg <= ~indicator_reg;
            end else begin
                count_reg <= count_reg + 8'd1;
            end
        end
    end

    assign status.at_last        = at_last;
    assign status.indicator_next = ~indicator_reg;

endmodule

@@ src/dust_low_pulse_occupancy_top.sv @@
`timescale 1ns / 1ps
// Top level of the dust sensor low-pulse occupancy meter.
//
//   Channel   Ports                              Carries
//   s_        s_valid / s_ready / s_item         edge or overflow tick events
//   m_        m_valid / m_ready / m_item         particle count at window close
//   cfg_      cfg_wr_en / cfg_addr / cfg_wdata   window length, edge compensation
//
// An event is taken into the input register and processed from there; if it
// closes the window, its result is loaded into the output register as the
// event leaves the input register, which raises m_valid.
// One event per cycle is sustained; the only stall is a window-closing tick
// meeting a full output register that is not being drained.
// Reset is synchronous, active low, resets all state but the two item registers, and clears both valid bits.
// Configuration writes take effect on the following cycle.
module dust_low_pulse_occupancy_top #(
    parameter int SUM_WIDTH = 40
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  dlpo_pkg::in_item_t   s_item,

    output logic                 m_valid,
    input  logic                 m_ready,
    output dlpo_pkg::out_item_t  m_item,

    input  logic                 cfg_wr_en,
    input  logic                 cfg_addr,
    input  logic [15:0]          cfg_wdata
);

    // Configuration registers
    logic [7:0]  window_last_reg;
    logic [15:0] edge_comp_reg;

    // Input stage
    logic                 in_valid_reg;
    dlpo_pkg::in_item_t   in_item_reg;

    // Output stage
    logic                 m_valid_reg;
    dlpo_pkg::out_item_t  m_item_reg;

    logic                  out_free;
    logic                  is_tick;
    logic                  close_cand;
    logic                  advance;
    logic                  emit;
    dlpo_pkg::evt_t        evt;
    dlpo_pkg::win_status_t win_status;
    logic [SUM_WIDTH-1:0]  low_sum;
    logic [15:0]           count_conv;

    // Hold configuration; writes must arrive only while the block is idle, a rule the block does not enforce
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_last_reg <= dlpo_pkg::WINDOW_LAST_RST;
            edge_comp_reg   <= dlpo_pkg::EDGE_COMP_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                dlpo_pkg::CFG_WINDOW_LAST: window_last_reg <= cfg_wdata[7:0];
                dlpo_pkg::CFG_EDGE_COMP:   edge_comp_reg   <= cfg_wdata;
                default:                   window_last_reg <= window_last_reg;
            endcase
        end
    end

    // Advance the staged event unless it closes the window into a blocked output
    assign out_free   = !m_valid_reg || m_ready;
    assign is_tick    = in_item_reg.command == dlpo_pkg::CMD_TICK;
    assign close_cand = in_valid_reg && is_tick && win_status.at_last;
    assign advance    = in_valid_reg && (!close_cand || out_free);
    assign emit       = advance && close_cand;
    assign s_ready    = !in_valid_reg || advance;

    // Qualify the event strobes; command 3 drops through with no effect
    assign evt.fall = advance && (in_item_reg.command == dlpo_pkg::CMD_FALL);
    assign evt.rise = advance && (in_item_reg.command == dlpo_pkg::CMD_RISE);
    assign evt.tick = advance && is_tick;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    dlpo_pulse_acc #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_pulse_acc (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .evt          (evt),
        .clear_sum    (emit),
        .timestamp_us (in_item_reg.timestamp_us),
        .edge_comp    (edge_comp_reg),
        .low_sum      (low_sum)
    );

    dlpo_window u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .evt         (evt),
        .window_last (window_last_reg),
        .status      (win_status)
    );

    dlpo_count_conv #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_count_conv (
        .low_sum        (low_sum),
        .particle_count (count_conv)
    );

    // Load the result on window close, drop valid once the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_item_reg.particle_count  <= count_conv;
            m_item_reg.indicator_level <= win_status.indicator_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

@@ src/dlpo_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks of the occupancy meter and their binding to the top level.
module dlpo_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input dlpo_pkg::out_item_t m_item
);

    logic last_ind_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_ind_reg <= 1'b0;
        end else if (m_valid && m_ready) begin
            last_ind_reg <= m_item.indicator_level;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed or dropped while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_indicator_toggle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.indicator_level == ~last_ind_reg)
        else $error("indicator did not toggle between windows");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a blocked result");

endmodule

bind dust_low_pulse_occupancy_top dlpo_checker u_dlpo_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

@@ tb/tb_dust_low_pulse_occupancy_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the dust sensor low-pulse occupancy meter.
module tb_dust_low_pulse_occupancy_top;

    localparam int          SUM_WIDTH     = 40;
    localparam int          CLK_PERIOD    = 10;
    localparam int          CYCLE_LIMIT   = 1_000_000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          TOTAL_ITEMS   = 800;
    localparam logic [1:0]  CMD_UNUSED    = 2'd3;
    localparam logic [63:0] SUM_LIMIT     = (64'd1 << SUM_WIDTH) - 64'd1;
    localparam logic [63:0] SUM_AT_KNEE   = 64'd2688000;
    localparam logic [63:0] COUNT_AT_KNEE = 64'd4500;

    // Shadow copy of the meter: registers, window state and the counts still owed
    class occupancy_scoreboard;
        logic [7:0]           window_last;
        logic [15:0]          edge_comp;
        logic [31:0]          fall_stamp;
        logic [31:0]          low_dur;
        logic [63:0]          low_sum;
        logic [7:0]           tick_count;
        logic                 indicator;
        dlpo_pkg::out_item_t  owed_counts[$];
        int                   mismatches;

        function new();
            window_last  = dlpo_pkg::WINDOW_LAST_RST;
            edge_comp    = dlpo_pkg::EDGE_COMP_RST;
            fall_stamp   = '0;
            low_dur      = '0;
            low_sum      = '0;
            tick_count   = '0;
            indicator    = 1'b0;
            mismatches   = 0;
        endfunction

        function void set_reg(logic addr, logic [15:0] data);
            if (addr == dlpo_pkg::CFG_WINDOW_LAST)
                window_last = data[7:0];
            else
                edge_comp = data;
        endfunction

        function logic [15:0] window_count(logic [63:0] s);
            logic [63:0] q;
            if (s <= SUM_AT_KNEE)
                q = (s * 64'd3) / 64'd1792;
            else
                q = COUNT_AT_KNEE + (s - SUM_AT_KNEE) / 64'd448;
            if (q > 64'd65535)
                q = 64'd65535;
            return q[15:0];
        endfunction

        function void note_event(dlpo_pkg::in_item_t ev);
            logic [31:0]         elapsed;
            logic [63:0]         d;
            dlpo_pkg::out_item_t res;
            unique case (ev.command)
                dlpo_pkg::CMD_FALL: fall_stamp = ev.timestamp_us;
                dlpo_pkg::CMD_RISE: begin
                    if (ev.timestamp_us > fall_stamp) begin
                        elapsed = ev.timestamp_us - fall_stamp;
                        d = {48'd0, edge_comp} + {32'd0, elapsed};
                        low_dur = (d > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
                    end
                    // stale duration is still accumulated
                    low_sum = low_sum + {32'd0, low_dur};
                    if (low_sum > SUM_LIMIT)
                        low_sum = SUM_LIMIT;
                end
                dlpo_pkg::CMD_TICK: begin
                    if (tick_count == window_last) begin
                        indicator           = ~indicator;
                        tick_count          = '0;
                        res.particle_count  = window_count(low_sum);
                        res.indicator_level = indicator;
                        low_sum             = '0;
                        owed_counts.push_back(res);
                    end else begin
                        tick_count = tick_count + 8'd1;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(dlpo_pkg::out_item_t got);
            dlpo_pkg::out_item_t want;
            if (owed_counts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected window result: count %0d indicator %0b",
                             $time, got.particle_count, got.indicator_level);
                return;
            end
            want = owed_counts.pop_front();
            if (got.particle_count !== want.particle_count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] particle_count mismatch: expected %0d, got %0d",
                             $time, want.particle_count, got.particle_count);
            end
            if (got.indicator_level !== want.indicator_level) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] indicator_level mismatch: expected %0b, got %0b",
                             $time, want.indicator_level, got.indicator_level);
            end
        endfunction
    endclass

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    dlpo_pkg::in_item_t  s_item    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    dlpo_pkg::out_item_t m_item;
    logic                cfg_wr_en = 1'b0;
    logic                cfg_addr  = 1'b0;
    logic [15:0]         cfg_wdata = '0;

    occupancy_scoreboard sb = new();

    bit          quiet      = 1'b0;   // suppress idling on both sides
    int          stall_left = 0;
    int          cycles     = 0;
    int          items_sent = 0;      // accepted transfers that touch state
    logic [31:0] clock_us   = '0;     // running time base of well-formed pulses

    dust_low_pulse_occupancy_top #(
        .SUM_WIDTH (SUM_WIDTH)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Abort on a hang
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_dust_low_pulse_occupancy_top: FAIL");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Low pulse lengths: zero (rise not after fall), typical, long, anything
    function automatic logic [31:0] pick_dur();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 32'd0;
        if (r < 70)
            return $urandom_range(1, 30000);
        if (r < 92)
            return $urandom_range(30000, 600000);
        return $urandom();
    endfunction

    // Stall the result side in random bursts
    always @(negedge aclk) begin
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 4) == 0)
                stall_left <= pick_gap();
        end
    end

    // Check every result transfer against the oldest owed count
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_item);
    end

    // Drive one event after a random gap; hold it until the transfer completes
    task automatic send_event(logic [1:0] cmd, logic [31:0] ts);
        int                 gap;
        dlpo_pkg::in_item_t ev;
        ev.command      = cmd;
        ev.timestamp_us = ts;
        gap             = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= ev;
        do
            @(posedge aclk);
        while (s_ready !== 1'b1);
        sb.note_event(ev);
        if (cmd != CMD_UNUSED)
            items_sent++;
    endtask

    // Fall then rise on the running time base
    task automatic send_pulse();
        logic [31:0] dur;
        dur = pick_dur();
        send_event(dlpo_pkg::CMD_FALL, clock_us);
        clock_us = clock_us + dur;
        send_event(dlpo_pkg::CMD_RISE, clock_us);
        clock_us = clock_us + $urandom_range(1, 5000);
    endtask

    // Drop valid, wait for every owed count, then let the pipeline empty
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.owed_counts.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic addr, logic [15:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_reg(addr, data);
    endtask

    // Overflow ticks with an occasional pulse in between
    task automatic tick_run(int n);
        repeat (n) begin
            if ($urandom_range(0, 7) == 0)
                send_pulse();
            send_event(dlpo_pkg::CMD_TICK, $urandom());
        end
    endtask

    // Mostly well-formed pulses and ticks, the rest stray edges and unused codes
    task automatic run_mix(int n, int tick_pct);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < tick_pct)
                send_event(dlpo_pkg::CMD_TICK, $urandom());
            else if (r < tick_pct + 50)
                send_pulse();
            else if (r < tick_pct + 62)
                send_event(dlpo_pkg::CMD_RISE, $urandom());
            else if (r < tick_pct + 72)
                send_event(dlpo_pkg::CMD_FALL, $urandom());
            else if (r < tick_pct + 80)
                send_event(dlpo_pkg::CMD_RISE, clock_us - $urandom_range(0, 2000));
            else
                send_event(CMD_UNUSED, $urandom());
        end
    endtask

    initial begin
        int          phase;
        int          r;
        logic [7:0]  win;
        logic [15:0] comp;

        repeat (12) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        repeat (4) @(posedge aclk);

        // Reset settings: eight-tick window, default compensation.
        // Rise at or before the stored fall keeps the old duration.
        send_event(dlpo_pkg::CMD_FALL, 32'h0000_0000);
        send_event(dlpo_pkg::CMD_RISE, 32'h0000_0000);
        send_event(dlpo_pkg::CMD_FALL, 32'd100);
        send_event(dlpo_pkg::CMD_RISE, 32'd50);
        // Duration saturates at all ones
        send_event(dlpo_pkg::CMD_RISE, 32'hFFFF_FFFF);
        send_event(dlpo_pkg::CMD_FALL, 32'hFFFF_FFFF);
        send_event(dlpo_pkg::CMD_RISE, 32'hFFFF_FFFF);
        send_event(CMD_UNUSED, 32'hAAAA_AAAA);
        send_event(CMD_UNUSED, 32'h5555_5555);
        repeat (8) send_event(dlpo_pkg::CMD_TICK, 32'hFFFF_FFFF);
        settle();

        // One-tick windows, no compensation: tiny sum, knee, just past knee, empty
        write_reg(dlpo_pkg::CFG_WINDOW_LAST, 16'hFF00);
        write_reg(dlpo_pkg::CFG_EDGE_COMP, 16'd0);
        send_event(dlpo_pkg::CMD_FALL, 32'd1000);
        send_event(dlpo_pkg::CMD_RISE, 32'd1001);
        send_event(dlpo_pkg::CMD_TICK, 32'h0000_0000);
        send_event(dlpo_pkg::CMD_FALL, 32'h0000_0000);
        send_event(dlpo_pkg::CMD_RISE, 32'd2688000);
        send_event(dlpo_pkg::CMD_TICK, 32'h0000_0000);
        send_event(dlpo_pkg::CMD_FALL, 32'h8000_0000);
        send_event(dlpo_pkg::CMD_RISE, 32'h8000_0000 + 32'd2688448);
        send_event(dlpo_pkg::CMD_TICK, 32'h0000_0000);
        send_event(dlpo_pkg::CMD_TICK, 32'h0000_0000);
        settle();

        // Sum saturation: fill to just under the top, then push past it
        write_reg(dlpo_pkg::CFG_EDGE_COMP, 16'hFFFF);
        send_event(dlpo_pkg::CMD_FALL, 32'h0000_0000);
        send_event(dlpo_pkg::CMD_RISE, 32'hFFFF_FFFF);
        repeat (255) send_event(dlpo_pkg::CMD_RISE, 32'h0000_0000);
        send_event(dlpo_pkg::CMD_FALL, 32'd16);
        send_event(dlpo_pkg::CMD_RISE, 32'd17);
        send_event(dlpo_pkg::CMD_TICK, 32'h0000_0000);
        settle();

        // Longest window: drive the count near the top, then lower the window
        // below it so the count wraps before the window closes
        write_reg(dlpo_pkg::CFG_WINDOW_LAST, 16'd255);
        write_reg(dlpo_pkg::CFG_EDGE_COMP, 16'd20000);
        tick_run(253);
        settle();
        write_reg(dlpo_pkg::CFG_WINDOW_LAST, 16'd1);
        tick_run(5);

        // Random phases with fresh settings each time
        phase = 0;
        while (items_sent < TOTAL_ITEMS && phase < 60) begin
            settle();
            quiet = 1'b0;
            r = $urandom_range(0, 19);
            if (r < 3)
                win = 8'd0;
            else if (r < 10)
                win = 8'($urandom_range(1, 3));
            else if (r < 17)
                win = 8'($urandom_range(4, 8));
            else if (r < 19)
                win = 8'd7;
            else
                win = 8'($urandom_range(0, 255));
            // Keep most windows reachable without a wrap of the tick count
            if (win < sb.tick_count && $urandom_range(0, 4) != 0)
                win = sb.tick_count + 8'($urandom_range(0, 3));
            write_reg(dlpo_pkg::CFG_WINDOW_LAST, {8'($urandom_range(0, 255)), win});
            if ($urandom_range(0, 1) == 0) begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    comp = 16'd0;
                else if (r == 1)
                    comp = 16'hFFFF;
                else if (r < 4)
                    comp = 16'd20000;
                else
                    comp = 16'($urandom_range(0, 65535));
                write_reg(dlpo_pkg::CFG_EDGE_COMP, comp);
            end
            quiet = ($urandom_range(0, 3) == 0);
            if (phase == 1) begin
                // Hold off the sender mid-phase until every count has come out
                run_mix(20, 25);
                settle();
                run_mix(20, 25);
            end else begin
                run_mix($urandom_range(20, 50), $urandom_range(10, 35));
            end
            phase++;
        end

        quiet = 1'b0;
        settle();
        if (sb.mismatches == 0 && sb.owed_counts.size() == 0)
            $display("tb_dust_low_pulse_occupancy_top: PASS");
        else
            $display("tb_dust_low_pulse_occupancy_top: FAIL");
        $finish;
    end

endmodule
